// ===== hdl/qrs_pkg.sv =====
package qrs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COEF_W = 32;
   localparam int ROOT_W = 32;
   localparam int SQ_STAGES = 34;
   localparam int SQ_RAD_W = 2 * SQ_STAGES;
   localparam int SQ_REM_W = SQ_STAGES + 2;
   localparam int NUM_W = 34;
   localparam int DEN_W = 33;
   localparam int DIV_QBITS = ROOT_W + 1;
   localparam int REM_W = DEN_W + 1;
   localparam int NUMER_W = NUM_W + FRAC_BITS + 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ST_TWO = 3'd0,
      ST_DOUBLE = 3'd1,
      ST_NONE = 3'd2,
      ST_LINEAR = 3'd3,
      ST_DEGEN = 3'd4
   } status_type;

   typedef struct packed {
      status_type status;
      logic two;
      logic [NUM_W-1:0] num0;
      logic neg0;
      logic [NUM_W-1:0] num1;
      logic neg1;
      logic [DEN_W-1:0] den;
   } job_type;

   function automatic logic [COEF_W-1:0] mag_of(logic [COEF_W-1:0] v);
      return v[COEF_W-1] ? (~v + COEF_W'(1)) : v;
   endfunction

endpackage

// ===== hdl/quadratic_root_solver_core.sv =====
// The front accepts a word every cycle while its output is not stalled; the divider pipeline in the back
// part issues one division per cycle while the response is not stalled, so an input with two roots
// issues two divisions, one per root, and one with a single result issues one.
// Reset is synchronous and clears all valid flags, queue pointers and the root phase.
module quadratic_root_solver_core import qrs_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [3*COEF_W-1:0] req_tdata,   // coef_a, coef_b, coef_c
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [ROOT_W-1:0] rsp_tdata,     // root
   output logic [4:0] rsp_tuser,            // root_index, status, saturated
   output logic rsp_tlast
);

   logic f_valid, f_ready, b_valid, b_ready;
   job_type f_job, b_job;

   qrs_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .out_valid(f_valid), .out_ready(f_ready), .out_job(f_job)
   );

   qrs_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
   );

   qrs_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(b_valid), .in_ready(b_ready), .in_job(b_job),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

endmodule

// ===== hdl/qrs_front.sv =====
module qrs_front import qrs_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [3*COEF_W-1:0] req_tdata,
   output logic out_valid,
   input  logic out_ready,
   output job_type out_job
);

   typedef struct packed {
      status_type status;
      logic [NUM_W-1:0] num0;
      logic neg0;
      logic [DEN_W-1:0] den;
      logic [COEF_W-1:0] b;
      logic a_neg;
      logic [SQ_RAD_W-1:0] rad;
      logic [SQ_REM_W-1:0] rem;
      logic [SQ_STAGES-1:0] root;
   } sq_type;

   logic en;
   logic s1_vld_ff;
   logic [COEF_W-1:0] s1_a_ff, s1_b_ff, s1_c_ff;
   logic s2_vld_ff;
   logic [COEF_W-1:0] s2_a_ff, s2_b_ff, s2_c_ff;
   logic [2*COEF_W-1:0] s2_p_ff, s2_m_ff;
   logic sq_vld_ff [0:SQ_STAGES];
   sq_type sq_ff [0:SQ_STAGES];
   sq_type sq_in [0:SQ_STAGES];
   sq_type sq_head;
   logic out_vld_ff;
   job_type out_job_ff, out_job_in;

   assign en = !out_vld_ff || out_ready;
   assign req_tready = en;
   assign out_valid = out_vld_ff;
   assign out_job = out_job_ff;

   always_comb begin
      logic [COEF_W-1:0] am, bm, cm;
      logic same;
      logic [2*COEF_W+1:0] m4, p66, d;
      am = mag_of(s2_a_ff);
      bm = mag_of(s2_b_ff);
      cm = mag_of(s2_c_ff);
      same = (s2_c_ff != '0) && (s2_a_ff[COEF_W-1] == s2_c_ff[COEF_W-1]);
      m4 = {s2_m_ff, 2'b00};
      p66 = {2'b00, s2_p_ff};
      d = same ? (p66 - m4) : (p66 + m4);
      sq_head = '0;
      sq_head.b = s2_b_ff;
      sq_head.a_neg = s2_a_ff[COEF_W-1];
      sq_head.den = {am, 1'b0};
      if (s2_a_ff == '0) begin
         sq_head.den = {1'b0, bm};
         if (s2_b_ff == '0) begin
            sq_head.status = ST_DEGEN;
            sq_head.den = DEN_W'(1);
         end else begin
            sq_head.status = ST_LINEAR;
            sq_head.num0 = NUM_W'(cm);
            sq_head.neg0 = (s2_c_ff[COEF_W-1] == s2_b_ff[COEF_W-1]);
         end
      end else if (same && (m4 > p66)) begin
         sq_head.status = ST_NONE;
         sq_head.den = DEN_W'(1);
      end else if (d == '0) begin
         sq_head.status = ST_DOUBLE;
         sq_head.num0 = NUM_W'(bm);
         sq_head.neg0 = (s2_b_ff[COEF_W-1] == s2_a_ff[COEF_W-1]);
      end else begin
         sq_head.status = ST_TWO;
         sq_head.rad = SQ_RAD_W'(d);
      end
   end

   always_comb begin
      logic [SQ_REM_W+1:0] rsh, trial;
      logic ge;
      sq_in[0] = sq_head;
      for (int i = 0; i < SQ_STAGES; i++) begin
         rsh = {sq_ff[i].rem, sq_ff[i].rad[SQ_RAD_W-1:SQ_RAD_W-2]};
         trial = {2'b00, sq_ff[i].root, 2'b01};
         ge = (rsh >= trial);
         sq_in[i+1] = sq_ff[i];
         sq_in[i+1].rem = ge ? SQ_REM_W'(rsh - trial) : SQ_REM_W'(rsh);
         sq_in[i+1].root = {sq_ff[i].root[SQ_STAGES-2:0], ge};
         sq_in[i+1].rad = {sq_ff[i].rad[SQ_RAD_W-3:0], 2'b00};
      end
   end

   always_comb begin
      logic [NUM_W+1:0] nb, n0, n1, s;
      s = {2'b00, sq_ff[SQ_STAGES].root};
      nb = -{{(NUM_W+2-COEF_W){sq_ff[SQ_STAGES].b[COEF_W-1]}}, sq_ff[SQ_STAGES].b};
      n0 = nb + s;
      n1 = nb - s;
      out_job_in.status = sq_ff[SQ_STAGES].status;
      out_job_in.den = sq_ff[SQ_STAGES].den;
      out_job_in.two = (sq_ff[SQ_STAGES].status == ST_TWO);
      out_job_in.num0 = sq_ff[SQ_STAGES].num0;
      out_job_in.neg0 = sq_ff[SQ_STAGES].neg0;
      out_job_in.num1 = '0;
      out_job_in.neg1 = 1'b0;
      if (out_job_in.two) begin
         out_job_in.num0 = NUM_W'(n0[NUM_W+1] ? -n0 : n0);
         out_job_in.neg0 = n0[NUM_W+1] != sq_ff[SQ_STAGES].a_neg;
         out_job_in.num1 = NUM_W'(n1[NUM_W+1] ? -n1 : n1);
         out_job_in.neg1 = n1[NUM_W+1] != sq_ff[SQ_STAGES].a_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i <= SQ_STAGES; i++) sq_vld_ff[i] <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
         s2_vld_ff <= s1_vld_ff;
         sq_vld_ff[0] <= s2_vld_ff;
         for (int i = 0; i < SQ_STAGES; i++) sq_vld_ff[i+1] <= sq_vld_ff[i];
         out_vld_ff <= sq_vld_ff[SQ_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_a_ff <= req_tdata[COEF_W-1:0];
         s1_b_ff <= req_tdata[2*COEF_W-1:COEF_W];
         s1_c_ff <= req_tdata[3*COEF_W-1:2*COEF_W];
         s2_a_ff <= s1_a_ff;
         s2_b_ff <= s1_b_ff;
         s2_c_ff <= s1_c_ff;
         s2_p_ff <= mag_of(s1_b_ff) * mag_of(s1_b_ff);
         s2_m_ff <= mag_of(s1_a_ff) * mag_of(s1_c_ff);
         for (int i = 0; i <= SQ_STAGES; i++) sq_ff[i] <= sq_in[i];
         out_job_ff <= out_job_in;
      end
   end

endmodule

// ===== hdl/qrs_queue.sv =====
module qrs_queue import qrs_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  job_type in_job,
   output logic out_valid,
   input  logic out_ready,
   output job_type out_job
);

   job_type mem_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_job = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_job;
   end

endmodule

// ===== hdl/qrs_back.sv =====
module qrs_back import qrs_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  job_type in_job,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [ROOT_W-1:0] rsp_tdata,
   output logic [4:0] rsp_tuser,
   output logic rsp_tlast
);

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DIV_QBITS-1:0] nlo;
      logic [DIV_QBITS-1:0] q;
      logic [REM_W-1:0] dvs;
      logic ovf;
      logic neg;
      logic idx;
      status_type status;
      logic last;
   } dv_type;

   logic en;
   logic phase_ff, phase_in;
   logic dv_vld_ff [0:DIV_QBITS];
   dv_type dv_ff [0:DIV_QBITS];
   dv_type dv_in [0:DIV_QBITS];
   dv_type dv_head;
   logic rsp_vld_ff;
   logic [ROOT_W-1:0] rsp_root_ff, rsp_root_in;
   logic [4:0] rsp_user_ff, rsp_user_in;
   logic rsp_last_ff;

   assign en = !rsp_vld_ff || rsp_tready;
   assign in_ready = en && (!in_job.two || phase_ff);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata = rsp_root_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tlast = rsp_last_ff;

   always_comb begin
      phase_in = phase_ff;
      if (in_valid) phase_in = in_job.two && !phase_ff;
   end

   always_comb begin
      logic [NUM_W-1:0] num;
      logic [NUMER_W-1:0] numer;
      num = phase_ff ? in_job.num1 : in_job.num0;
      numer = (NUMER_W'(num) << (FRAC_BITS + 1)) + NUMER_W'(in_job.den);
      dv_head.dvs = {in_job.den, 1'b0};
      dv_head.rem = REM_W'(numer[NUMER_W-1:DIV_QBITS]);
      dv_head.nlo = numer[DIV_QBITS-1:0];
      dv_head.q = '0;
      dv_head.ovf = (REM_W'(numer[NUMER_W-1:DIV_QBITS]) >= dv_head.dvs);
      dv_head.neg = phase_ff ? in_job.neg1 : in_job.neg0;
      dv_head.idx = phase_ff;
      dv_head.status = in_job.status;
      dv_head.last = !in_job.two || phase_ff;
   end

   always_comb begin
      logic [REM_W:0] rsh;
      logic ge;
      dv_in[0] = dv_head;
      for (int i = 0; i < DIV_QBITS; i++) begin
         rsh = {dv_ff[i].rem, dv_ff[i].nlo[DIV_QBITS-1]};
         ge = (rsh >= {1'b0, dv_ff[i].dvs});
         dv_in[i+1] = dv_ff[i];
         dv_in[i+1].rem = ge ? REM_W'(rsh - {1'b0, dv_ff[i].dvs}) : REM_W'(rsh);
         dv_in[i+1].q = {dv_ff[i].q[DIV_QBITS-2:0], ge};
         dv_in[i+1].nlo = {dv_ff[i].nlo[DIV_QBITS-2:0], 1'b0};
      end
   end

   always_comb begin
      logic [DIV_QBITS-1:0] q;
      logic sat;
      logic [ROOT_W-1:0] m;
      q = dv_ff[DIV_QBITS].q;
      if (dv_ff[DIV_QBITS].neg)
         sat = dv_ff[DIV_QBITS].ovf || q[ROOT_W] || (q[ROOT_W-1] && (q[ROOT_W-2:0] != '0));
      else
         sat = dv_ff[DIV_QBITS].ovf || q[ROOT_W] || q[ROOT_W-1];
      if (sat) m = dv_ff[DIV_QBITS].neg ? {1'b1, {(ROOT_W-1){1'b0}}}
                                        : {1'b0, {(ROOT_W-1){1'b1}}};
      else m = q[ROOT_W-1:0];
      rsp_root_in = dv_ff[DIV_QBITS].neg ? -m : m;
      rsp_user_in = {sat, dv_ff[DIV_QBITS].status, dv_ff[DIV_QBITS].idx};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i <= DIV_QBITS; i++) dv_vld_ff[i] <= 1'b0;
      end else if (en) begin
         phase_ff <= phase_in;
         dv_vld_ff[0] <= in_valid;
         for (int i = 0; i < DIV_QBITS; i++) dv_vld_ff[i+1] <= dv_vld_ff[i];
         rsp_vld_ff <= dv_vld_ff[DIV_QBITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= DIV_QBITS; i++) dv_ff[i] <= dv_in[i];
         rsp_root_ff <= rsp_root_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= dv_ff[DIV_QBITS].last;
      end
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

import qrs_pkg::*;

class root_scoreboard;
   logic [31:0] exp_root[$];
   logic exp_index[$];
   status_type exp_status[$];
   logic exp_sat[$];
   logic exp_last[$];
   int errors;

   function new();
      errors = 0;
   endfunction

   function void push(logic [31:0] r, logic idx, status_type st, logic sat, logic lst);
      exp_root = {exp_root, r};
      exp_index = {exp_index, idx};
      exp_status = {exp_status, st};
      exp_sat = {exp_sat, sat};
      exp_last = {exp_last, lst};
   endfunction

   // Rounded quotient of num*2^F/den, ties away from zero, clamped to 32 bits.
   function automatic logic [31:0] scaled_quotient(logic [63:0] num, logic [63:0] den,
                                                   logic neg, output logic sat);
      logic [127:0] un;
      logic [127:0] q;
      un = {64'd0, num} << qrs_pkg::FRAC_BITS;
      q = (2 * un + den) / (2 * {64'd0, den});
      sat = 1'b0;
      if (!neg) begin
         if (q > 128'h7FFF_FFFF) begin
            q = 128'h7FFF_FFFF;
            sat = 1'b1;
         end
         return q[31:0];
      end
      if (q > 128'h8000_0000) begin
         q = 128'h8000_0000;
         sat = 1'b1;
      end
      return -q[31:0];
   endfunction

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   // Works out the roots of one accepted coefficient word.
   function void note_coefficients(logic [31:0] ra, logic [31:0] rb, logic [31:0] rc);
      longint a, b, c, num;
      logic signed [127:0] disc;
      logic [127:0] sq, t;
      logic [31:0] r;
      logic sat;
      a = longint'(signed'(ra));
      b = longint'(signed'(rb));
      c = longint'(signed'(rc));
      if (a == 0) begin
         if (b == 0) push(0, 0, ST_DEGEN, 0, 1);
         else if (c == 0) push(0, 0, ST_LINEAR, 0, 1);
         else begin
            r = scaled_quotient(magnitude(c), magnitude(b), (c < 0) == (b < 0), sat);
            push(r, 0, ST_LINEAR, sat, 1);
         end
         return;
      end
      disc = 128'(b) * 128'(b) - 4 * 128'(a) * 128'(c);
      if (disc < 0) begin
         push(0, 0, ST_NONE, 0, 1);
         return;
      end
      if (disc == 0) begin
         if (b == 0) push(0, 0, ST_DOUBLE, 0, 1);
         else begin
            r = scaled_quotient(magnitude(b), 2 * magnitude(a), (b < 0) == (a < 0), sat);
            push(r, 0, ST_DOUBLE, sat, 1);
         end
         return;
      end
      sq = 0;
      for (int i = 33; i >= 0; i--) begin
         t = sq | (128'd1 << i);
         if (t * t <= disc) sq = t;
      end
      for (int k = 0; k < 2; k++) begin
         num = (k == 0) ? -b + longint'(sq) : -b - longint'(sq);
         if (num == 0) push(0, k[0], ST_TWO, 0, k[0]);
         else begin
            r = scaled_quotient(magnitude(num), 2 * magnitude(a), (num < 0) != (a < 0), sat);
            push(r, k[0], ST_TWO, sat, k[0]);
         end
      end
   endfunction

   function void check_root(logic [31:0] r, logic [4:0] user, logic lst);
      if (exp_root.size() == 0) begin
         $error("unexpected root word %h", r);
         errors++;
         return;
      end
      if (r !== exp_root[0]) begin
         $error("root expected %h actual %h", exp_root[0], r);
         errors++;
      end
      if (user[0] !== exp_index[0]) begin
         $error("root_index expected %0d actual %0d", exp_index[0], user[0]);
         errors++;
      end
      if (user[3:1] !== exp_status[0]) begin
         $error("status expected %0d actual %0d", exp_status[0], user[3:1]);
         errors++;
      end
      if (user[4] !== exp_sat[0]) begin
         $error("saturated expected %0d actual %0d", exp_sat[0], user[4]);
         errors++;
      end
      if (lst !== exp_last[0]) begin
         $error("last expected %0d actual %0d", exp_last[0], lst);
         errors++;
      end
      void'(exp_root.pop_front());
      void'(exp_index.pop_front());
      void'(exp_status.pop_front());
      void'(exp_sat.pop_front());
      void'(exp_last.pop_front());
   endfunction
endclass

module testbench;
   import qrs_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [95:0] req_tdata = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic [4:0] rsp_tuser;
   logic rsp_tlast;
   logic hold_off = 0;
   logic sending_done = 0;
   root_scoreboard board = new();

   quadratic_root_solver_core uut (.*);

   always #5 clock = ~clock;

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 0;
         3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
         4, 5: return 32'(int'($urandom_range(0, 20)) - 10) << 16;
         6: return 32'(int'($urandom_range(0, 4000)) - 2000);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(logic [31:0] a, logic [31:0] b, logic [31:0] c, bit gaps);
      int wait_cycles;
      wait_cycles = gaps ? $urandom_range(0, 19) : 0;
      if (wait_cycles > 0) begin
         req_tvalid <= 0;
         repeat (wait_cycles) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {c, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_coefficients(a, b, c);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.exp_root.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] a, b, c, k;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_word(0, 0, 32'h0001_0000, 0);
      send_word(0, 0, 0, 0);
      send_word(0, 32'h0002_0000, 0, 0);
      send_word(0, 32'h0002_0000, 32'h0004_0000, 0);
      send_word(0, 32'h0000_0001, 32'h7FFF_FFFF, 0);
      send_word(0, 32'h8000_0000, 32'h8000_0000, 0);
      send_word(32'h0001_0000, 0, 32'h0001_0000, 0);
      send_word(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 0);
      send_word(32'h0001_0000, 0, 0, 0);
      send_word(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000, 0);
      send_word(32'h0001_0000, 0, 32'hFFFC_0000, 0);
      send_word(32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0001, 0);
      send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_word(32'h0000_0001, 0, 32'h8000_0000, 0);
      drain();
      hold_off <= 1;
      for (int i = 0; i < 150; i++) send_word($urandom, $urandom, $urandom, 0);
      drain();
      for (int i = 0; i < 1500; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            // Built from small whole-number coefficients, c often zero, so that exact and double roots come often.
            k = 32'(int'($urandom_range(0, 6)) - 3);
            a = k << 16;
            b = 32'(int'($urandom_range(0, 40)) - 20) << 16;
            c = $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 40)) - 20) << 16 : 0;
            if (k == 0) a = 32'h0001_0000;
         end else begin
            a = pick_coef();
            b = pick_coef();
            c = pick_coef();
         end
         send_word(a, b, c, (i / 100) % 3 != 0);
      end
      req_tvalid <= 0;
      sending_done <= 1;
   end

   initial begin
      int wait_cycles;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            hold_off <= 0;
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
         end
         wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
         if (wait_cycles > 0) begin
            rsp_tready <= 0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_root(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   initial begin
      wait (sending_done);
      while (board.exp_root.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

// ===== files.f =====
hdl/qrs_pkg.sv
hdl/qrs_front.sv
hdl/qrs_queue.sv
hdl/qrs_back.sv
hdl/quadratic_root_solver_core.sv
verif/testbench.sv
